### rtl/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// command and result beats, event codes, controller/datapath handshake structs
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int SLOT_W = 4;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  // event codes
  localparam logic [2:0] EV_ADDED   = 3'd0;
  localparam logic [2:0] EV_FULL    = 3'd1;
  localparam logic [2:0] EV_DELETED = 3'd2;
  localparam logic [2:0] EV_EXPIRED = 3'd3;
  localparam logic [2:0] EV_QUIET   = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period;
    logic        periodic;
    logic [31:0] tag;
    logic [7:0]  timer_id;
  } in_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       expired_tag;
    logic [31:0]       tick_count;
    logic              last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch command beat, restart slot walk
    logic tick;      // bump global tick counter
    logic scan;      // tick walk over the slots
    logic tfin;      // emit final tick result
    logic add_step;  // test one slot for add
    logic del;       // free the addressed slot
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic proc_last; // last slot of the tick walk is being processed
    logic add_done;  // add found a free slot or ran out of slots
  } stat_t;

endpackage

### rtl/ptb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ctrl: command sequencer of the periodic timer bank
// decodes accepted commands and steps the datapath through each one
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      cmd,
  input  ptb_pkg::stat_t  stat,
  output ptb_pkg::ctrl_t  ctrl,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TFIN,
    S_ADD,
    S_DEL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          case (cmd)
            ptb_pkg::CMD_TICK: begin
              ctrl.tick = 1'b1;
              state_nxt = S_TICK;
            end
            ptb_pkg::CMD_ADD: state_nxt = S_ADD;
            ptb_pkg::CMD_DEL: state_nxt = S_DEL;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        ctrl.scan = 1'b1;
        if (stat.proc_last) state_nxt = S_TFIN;
      end
      S_TFIN: begin
        ctrl.tfin = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ADD: begin
        ctrl.add_step = 1'b1;
        if (stat.add_done) state_nxt = S_IDLE;
      end
      S_DEL: begin
        ctrl.del  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/ptb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_dpath: slot storage and result datapath of the periodic timer bank
// entry memory, active bits, tick counter, slot walk and result register
// ----------------------------------------------------------------------------
module ptb_dpath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ptb_pkg::in_t    in_data,
  input  ptb_pkg::ctrl_t  ctrl,
  output ptb_pkg::stat_t  stat,
  output logic            out_valid,
  output ptb_pkg::out_t   out_data
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] elapsed;
    logic        periodic;
    logic [31:0] tag;
  } entry_t;

  entry_t entry_mem [NUM_TIMERS];

  ptb_pkg::in_t                 item_r, item_nxt;
  logic [31:0]                  ticks_r, ticks_nxt;
  logic [NUM_TIMERS-1:0]        active_r, active_nxt;
  logic [IW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         rd_live_r, rd_live_nxt;
  logic                         proc_vld_r, proc_vld_nxt;
  logic [IW-1:0]                proc_idx_r, proc_idx_nxt;
  entry_t                       rdata_r;
  logic                         pend_vld_r, pend_vld_nxt;
  logic [ptb_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [31:0]                  pend_tag_r, pend_tag_nxt;
  logic                         out_vld_r, out_vld_nxt;
  ptb_pkg::out_t                out_r, out_nxt;

  logic        wr_en;
  logic [IW-1:0] wr_idx;
  entry_t      wr_data;
  logic        rd_en;

  logic        proc_hit, proc_exp;
  logic [15:0] el_inc;
  logic        add_free, add_end, del_in;

  assign rd_en    = ctrl.scan && rd_live_r;
  assign proc_hit = proc_vld_r && active_r[proc_idx_r];
  assign el_inc   = rdata_r.elapsed + 16'd1;
  assign proc_exp = proc_hit && (rdata_r.period != 16'd0) && (el_inc == rdata_r.period);
  assign add_free = !active_r[rd_idx_r];
  assign add_end  = (rd_idx_r == LAST_IDX);
  assign del_in   = (item_r.timer_id < 8'(NUM_TIMERS));

  assign stat.proc_last = proc_vld_r && (proc_idx_r == LAST_IDX);
  assign stat.add_done  = add_free || add_end;

  always_comb begin
    item_nxt      = item_r;
    ticks_nxt     = ticks_r;
    active_nxt    = active_r;
    rd_idx_nxt    = rd_idx_r;
    rd_live_nxt   = rd_live_r;
    proc_vld_nxt  = rd_en;
    proc_idx_nxt  = rd_idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    pend_tag_nxt  = pend_tag_r;
    out_vld_nxt   = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_idx        = proc_idx_r;
    wr_data       = rdata_r;

    if (ctrl.load) begin
      item_nxt     = in_data;
      rd_idx_nxt   = '0;
      rd_live_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
      if (ctrl.tick) ticks_nxt = ticks_r + 32'd1;
    end

    // read side of the tick walk
    if (rd_en) begin
      rd_idx_nxt  = rd_idx_r + IW'(1);
      rd_live_nxt = (rd_idx_r != LAST_IDX);
    end

    // process side: one slot behind the read
    if (proc_hit) begin
      wr_en           = 1'b1;
      wr_idx          = proc_idx_r;
      wr_data.elapsed = proc_exp ? 16'd0 : el_inc;
      if (proc_exp) begin
        if (!rdata_r.periodic) active_nxt[proc_idx_r] = 1'b0;
        // a newer expiry exists, so the held one is not the last beat
        if (pend_vld_r) begin
          out_vld_nxt = 1'b1;
          out_nxt     = '{ptb_pkg::EV_EXPIRED, pend_slot_r, pend_tag_r, ticks_r, 1'b0};
        end
        pend_vld_nxt  = 1'b1;
        pend_slot_nxt = ptb_pkg::SLOT_W'(proc_idx_r);
        pend_tag_nxt  = rdata_r.tag;
      end
    end

    if (ctrl.tfin) begin
      out_vld_nxt = 1'b1;
      if (pend_vld_r) begin
        out_nxt = '{ptb_pkg::EV_EXPIRED, pend_slot_r, pend_tag_r, ticks_r, 1'b1};
      end else begin
        out_nxt = '{ptb_pkg::EV_QUIET, '0, 32'd0, ticks_r, 1'b1};
      end
    end

    if (ctrl.add_step) begin
      if (add_free) begin
        wr_en                = 1'b1;
        wr_idx               = rd_idx_r;
        wr_data.period       = item_r.period;
        wr_data.elapsed      = 16'd0;
        wr_data.periodic     = item_r.periodic;
        wr_data.tag          = item_r.tag;
        active_nxt[rd_idx_r] = 1'b1;
        out_vld_nxt          = 1'b1;
        out_nxt = '{ptb_pkg::EV_ADDED, ptb_pkg::SLOT_W'(rd_idx_r), 32'd0, ticks_r, 1'b1};
      end else if (add_end) begin
        out_vld_nxt = 1'b1;
        out_nxt     = '{ptb_pkg::EV_FULL, '0, 32'd0, ticks_r, 1'b1};
      end else begin
        rd_idx_nxt = rd_idx_r + IW'(1);
      end
    end

    if (ctrl.del) begin
      if (del_in) active_nxt[item_r.timer_id[IW-1:0]] = 1'b0;
      out_vld_nxt = 1'b1;
      out_nxt     = '{ptb_pkg::EV_DELETED, '0, 32'd0, ticks_r, 1'b1};
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) entry_mem[wr_idx] <= wr_data;
    if (rd_en) rdata_r <= entry_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= 32'd0;
      active_r   <= '0;
      rd_live_r  <= 1'b0;
      proc_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      ticks_r    <= ticks_nxt;
      active_r   <= active_nxt;
      rd_live_r  <= rd_live_nxt;
      proc_vld_r <= proc_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    item_r      <= item_nxt;
    rd_idx_r    <= rd_idx_nxt;
    proc_idx_r  <= proc_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### rtl/periodic_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank: bank of periodic and one-shot timers
// commands add, delete and tick; each tick walks all slots and reports expiries
// ----------------------------------------------------------------------------
// tick: walks one slot per cycle through the entry memory read port; expiry
//   beats stream out during the walk, last beat in the cycle busy drops
// add: tests slots upward from 0 until a free one or the last; delete frees an in-range id
// add and delete beats appear in the cycle busy drops; unused code: no beat
// one command at a time; each beat is valid for a single cycle, receiver cannot stall
// reset clears active bits and tick counter; entry memory is not cleared
module periodic_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ptb_pkg::in_t  in_data,
  output logic          out_valid,
  output ptb_pkg::out_t out_data
);

  ptb_pkg::ctrl_t ctrl;
  ptb_pkg::stat_t stat;
  logic           accept;

  // a command beat is taken only while the sequencer is idle
  assign accept = start && !busy;

  // sequencer: decodes the command and paces the slot walk
  ptb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_data.cmd),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // storage, tick counter, result register
  ptb_dpath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // final beat of a command only shows once the sequencer is back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("last beat while busy");

  // delete answers with exactly one beat, through the S_DEL state and the result register
  a_del_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.cmd == ptb_pkg::CMD_DEL) |=> ##1
      (out_valid && out_data.last && (out_data.event_kind == ptb_pkg::EV_DELETED)))
    else $error("delete beat missing");

  // only expiry beats carry a tag
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != ptb_pkg::EV_EXPIRED) |-> (out_data.expired_tag == 32'd0))
    else $error("tag on non-expiry beat");

endmodule

### verif/ptb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_checker: result checker for the periodic timer bank
// tracks the timer slots and tick counter beside the dut, predicts the
// result beats of every accepted command and compares them in order
// ----------------------------------------------------------------------------
module ptb_checker import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  logic        slot_active   [NUM_TIMERS];
  logic [15:0] slot_period   [NUM_TIMERS];
  logic [15:0] slot_elapsed  [NUM_TIMERS];
  logic        slot_periodic [NUM_TIMERS];
  logic [31:0] slot_tag      [NUM_TIMERS];
  logic [31:0] tick_total;

  out_t timer_events[$];
  int   errors = 0;

  // one beat is held back so the final one can get its last flag
  out_t held_event;
  bit   have_held;

  function automatic out_t make_event(logic [2:0] kind, int idx, logic [31:0] tag);
    out_t ev;
    ev.event_kind  = kind;
    ev.slot        = idx[SLOT_W-1:0];
    ev.expired_tag = tag;
    ev.tick_count  = tick_total;
    ev.last        = 1'b0;
    return ev;
  endfunction

  task automatic queue_event(out_t ev);
    if (have_held) timer_events.push_back(held_event);
    held_event = ev;
    have_held  = 1'b1;
  endtask

  task automatic run_timer_command(in_t beat);
    int fired;
    int idx;
    fired     = 0;
    have_held = 1'b0;
    case (beat.cmd)
      CMD_TICK: begin
        tick_total = tick_total + 32'd1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (slot_active[i]) begin
            slot_elapsed[i] = slot_elapsed[i] + 16'd1;
            if (slot_period[i] != 16'd0 && slot_elapsed[i] == slot_period[i]) begin
              slot_elapsed[i] = 16'd0;
              queue_event(make_event(EV_EXPIRED, i, slot_tag[i]));
              fired++;
              if (!slot_periodic[i]) slot_active[i] = 1'b0;
            end
          end
        end
        if (fired == 0) queue_event(make_event(EV_QUIET, 0, 32'd0));
      end
      CMD_ADD: begin
        idx = 0;
        while (idx < NUM_TIMERS && slot_active[idx]) idx++;
        if (idx < NUM_TIMERS) begin
          slot_period[idx]   = beat.period;
          slot_periodic[idx] = beat.periodic;
          slot_tag[idx]      = beat.tag;
          slot_elapsed[idx]  = 16'd0;
          slot_active[idx]   = 1'b1;
          queue_event(make_event(EV_ADDED, idx, 32'd0));
        end else begin
          queue_event(make_event(EV_FULL, 0, 32'd0));
        end
      end
      CMD_DEL: begin
        if (int'(beat.timer_id) < NUM_TIMERS) slot_active[beat.timer_id] = 1'b0;
        queue_event(make_event(EV_DELETED, 0, 32'd0));
      end
      default: ; // unused code, no beat
    endcase
    if (have_held) begin
      held_event.last = 1'b1;
      timer_events.push_back(held_event);
    end
  endtask

  task automatic check_event(out_t got);
    out_t want;
    if (timer_events.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected beat kind=%0d slot=%0d tag=%h ticks=%0d last=%b",
                 $time, got.event_kind, got.slot, got.expired_tag, got.tick_count,
                 got.last);
    end else begin
      want = timer_events.pop_front();
      if (got.event_kind !== want.event_kind || got.slot !== want.slot ||
          got.expired_tag !== want.expired_tag || got.tick_count !== want.tick_count ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: beat mismatch exp kind=%0d slot=%0d tag=%h ticks=%0d last=%b",
                   $time, want.event_kind, want.slot, want.expired_tag,
                   want.tick_count, want.last,
                   "\n            got kind=%0d slot=%0d tag=%h ticks=%0d last=%b",
                   got.event_kind, got.slot, got.expired_tag, got.tick_count,
                   got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_active[i]   = 1'b0;
        slot_period[i]   = 16'd0;
        slot_elapsed[i]  = 16'd0;
        slot_periodic[i] = 1'b0;
        slot_tag[i]      = 32'd0;
      end
      tick_total = 32'd0;
      timer_events.delete();
    end else begin
      // command side first: its beats can only show up on later edges
      if (start && !busy) run_timer_command(in_data);
      if (out_valid) check_event(out_data);
    end
    pending    <= timer_events.size();
    fail_count <= errors;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the periodic timer bank
// directed commands for the corner cases (empty bank, out-of-range and free
// deletes, zero period, full bank, unused code), then random add, delete and
// tick traffic with random gaps; ptb_checker predicts and compares every beat
// ----------------------------------------------------------------------------
module tb;
  import ptb_pkg::*;

  localparam int NUM_TIMERS  = 16;
  localparam int NUM_RANDOM  = 80;
  localparam int IDLE_LIMIT  = 1000;    // cycles with no beat moving either way
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  periodic_timer_bank #(
    .NUM_TIMERS (NUM_TIMERS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  ptb_checker #(
    .NUM_TIMERS (NUM_TIMERS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // all fields random; fields a command does not use stay random too
  function automatic in_t rand_beat();
    in_t b;
    b.cmd      = 2'($urandom);
    b.period   = 16'($urandom);
    b.periodic = 1'($urandom);
    b.tag      = $urandom;
    b.timer_id = 8'($urandom);
    return b;
  endfunction

  function automatic in_t tick_cmd();
    in_t b;
    b     = rand_beat();
    b.cmd = CMD_TICK;
    return b;
  endfunction

  function automatic in_t add_cmd(logic [15:0] period, logic periodic, logic [31:0] tag);
    in_t b;
    b          = rand_beat();
    b.cmd      = CMD_ADD;
    b.period   = period;
    b.periodic = periodic;
    b.tag      = tag;
    return b;
  endfunction

  function automatic in_t del_cmd(logic [7:0] id);
    in_t b;
    b          = rand_beat();
    b.cmd      = CMD_DEL;
    b.timer_id = id;
    return b;
  endfunction

  // mostly short periods so expiries happen often, a few zero or huge ones
  function automatic logic [15:0] rand_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 90) return 16'($urandom_range(7, 40));
    return 16'($urandom);
  endfunction

  // raise start with the beat and hold it until the dut takes it;
  // start is left high so back-to-back beats need no second assignment
  task automatic issue(in_t beat);
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
  endtask

  // drop start for a number of cycles, with junk on the data lines
  task automatic pause(int cycles);
    if (cycles > 0) begin
      start   <= 1'b0;
      in_data <= rand_beat();
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      pause(0);
    else if (r < 90) pause($urandom_range(1, 3));
    else             pause($urandom_range(8, 30));
  endtask

  // hold off until every predicted beat has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // watchdog: ends the run if no beat moves on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** periodic_timer_bank: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int done;
    int sel;
    logic [7:0] id;

    start   <= 1'b0;
    in_data <= '0;
    rst_n   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n   <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // tick on an empty bank gives a quiet beat
    issue(tick_cmd());
    random_gap();
    // delete of a free slot, then out-of-range ids at the edge and the top
    issue(del_cmd(8'd0));
    random_gap();
    issue(del_cmd(8'd255));
    random_gap();
    issue(del_cmd(8'(NUM_TIMERS)));
    random_gap();
    // unused command code, no beat expected
    issue(add_cmd(16'hffff, 1'b1, 32'hffff_ffff) ^ {CMD_ADD ^ CMD_UNUSED, 57'd0});
    random_gap();
    // zero period in slot 0 never expires; slot 1 has the largest period
    issue(add_cmd(16'd0, 1'b0, 32'd0));
    random_gap();
    issue(add_cmd(16'hffff, 1'b1, 32'hffff_ffff));
    random_gap();
    // fill the rest with short timers, one-shot and periodic alternating
    for (int k = 2; k < NUM_TIMERS; k++) begin
      issue(add_cmd(16'($urandom_range(1, 2)), 1'(k), $urandom));
      random_gap();
    end
    // bank is full now
    issue(add_cmd(16'd1, 1'b1, $urandom));
    random_gap();
    // ticks with many expiries in one beat train; one-shots get freed
    issue(tick_cmd());
    random_gap();
    issue(tick_cmd());
    random_gap();
    issue(del_cmd(8'(NUM_TIMERS - 1)));
    drain();

    // ---- random part ----
    done = 0;
    while (done < NUM_RANDOM) begin
      sel = $urandom_range(0, 99);
      if (sel < 42) begin
        issue(tick_cmd());
        done++;
      end else if (sel < 76) begin
        issue(add_cmd(rand_period(), 1'($urandom), $urandom));
        done++;
      end else if (sel < 95) begin
        // mostly in-range slot ids, sometimes any 8-bit id
        if ($urandom_range(0, 4) != 0) id = 8'($urandom_range(0, NUM_TIMERS - 1));
        else id = 8'($urandom);
        issue(del_cmd(id));
        done++;
      end else begin
        // ignored code; not counted
        issue(add_cmd(rand_period(), 1'($urandom), $urandom)
              ^ {CMD_ADD ^ CMD_UNUSED, 57'd0});
      end
      // let the bank run dry of work at 30 and 60 counted commands
      if (done == 30 || done == 60) drain();
      // every third stretch of a dozen beats goes back-to-back
      else if ((done / 12) % 3 == 2) pause(0);
      else random_gap();
    end

    // wait for the tail beats, then a little longer for any stray ones
    drain();
    repeat (NUM_TIMERS + 8) @(posedge clk);

    if (fail_count == 0) $display("** periodic_timer_bank: PASSED **");
    else $display("** periodic_timer_bank: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/ptb_pkg.sv
rtl/ptb_ctrl.sv
rtl/ptb_dpath.sv
rtl/periodic_timer_bank.sv
verif/ptb_checker.sv
verif/tb.sv
